// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file
// Short wrappers around concurrent assertions clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge while not in reset.
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication checked at every rising edge while not in reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ----- rtl/fdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdc_pkg
// Types and constants of the frame deframer with CRC-16 check.
// ----------------------------------------------------------------------------
`default_nettype none
package fdc_pkg;

   typedef enum logic [3:0] {
      PH_IDLE, PH_HEADER, PH_HDRBAD, PH_ROUTE, PH_LENGTH, PH_STAMP,
      PH_RESV, PH_PAYLOAD, PH_CRC, PH_TAIL, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0, KIND_ACCEPT = 2'd1, KIND_REJECT = 2'd2
   } kind_type;

   localparam logic [2:0] RSN_NONE   = 3'd0;
   localparam logic [2:0] RSN_EARLY  = 3'd1;
   localparam logic [2:0] RSN_HEADER = 3'd2;
   localparam logic [2:0] RSN_TAIL   = 3'd3;
   localparam logic [2:0] RSN_CRC    = 3'd4;

   localparam logic [1:0] REG_HEADER = 2'd0;
   localparam logic [1:0] REG_TAIL   = 2'd1;
   localparam logic [1:0] REG_SHIFT  = 2'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // One queue entry: up to two results from one input byte.
   typedef struct packed {
      logic        pay_valid;
      logic [7:0]  pay_byte;
      logic        stat_valid;
      logic [1:0]  stat_kind;
      logic [2:0]  stat_type;
      logic [63:0] stat_len;
      logic [63:0] stat_time;
      logic [2:0]  stat_reason;
   } entry_type;

   // Byte-wide CRC-16/CCITT-FALSE update (fixed XOR network).
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/frame_deframer_crc16_check.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check
// Deframer for length-prefixed frames with a CRC-16/CCITT-FALSE check.
// ----------------------------------------------------------------------------
// Usage:
//  Input bytes arrive on req_ with tuser = first byte of buffer and tlast =
//  last byte of buffer. Payload bytes leave on rsp_ as kind 0; at the tail a
//  single status transaction reports acceptance or a reject reason. rsp_tlast
//  marks the last result caused by one input byte.
//  Results pass through the queue and the output register. The parser takes one
//  byte per cycle while the queue is not full; the byte-wide CRC XOR network
//  in the parser sets that. A byte that causes two results (final payload
//  byte then early end) gives two transactions; a two-entry queue absorbs it.
//  When the receiver stalls, the queue fills and req_tready drops.
//  Reset clears parsing state and the registers to zero; no clearing pass.
//  The user writes configuration through the csr_ APB port while idle; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module frame_deframer_crc16_check
   import fdc_pkg::*;
#(
   parameter int RESERVED_BYTES = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] first_byte
   input  wire logic         req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [1:0] out_kind, [9:2] out_byte, [12:10] frame_type, [76:13] payload_length,
   // [140:77] frame_time, [143:141] reject_reason, [151:144] zero fill
   output logic [151:0]      rsp_tdata,
   output logic              rsp_tlast,   // run_last
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [15:0] hdr_ff, tail_ff;
   logic [3:0]  shift_ff;
   logic        take, q_full, q_empty, q_pop, p_valid;
   entry_type   p_ent, q_ent;
   logic [1:0]  o_kind;
   logic [7:0]  o_byte;
   logic [2:0]  o_type, o_rsn;
   logic [63:0] o_len, o_time;
   logic [1:0]  reg_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= '0;
         tail_ff  <= '0;
         shift_ff <= '0;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         case (reg_idx)
            REG_HEADER: hdr_ff   <= csr_pwdata[15:0];
            REG_TAIL:   tail_ff  <= csr_pwdata[15:0];
            REG_SHIFT:  shift_ff <= csr_pwdata[3:0];
            default:    hdr_ff   <= hdr_ff;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (reg_idx)
         REG_HEADER: csr_prdata = {16'd0, hdr_ff};
         REG_TAIL:   csr_prdata = {16'd0, tail_ff};
         REG_SHIFT:  csr_prdata = {28'd0, shift_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   fdc_parser #(.RESERVED_BYTES(RESERVED_BYTES)) u_parser (
      .clock(clock), .reset(reset), .in_take(take), .in_byte(req_tdata),
      .in_first(req_tuser), .in_last(req_tlast), .header_magic(hdr_ff),
      .tail_magic(tail_ff), .type_shift(shift_ff), .ent(p_ent), .ent_valid(p_valid)
   );

   fdc_queue u_queue (
      .clock(clock), .reset(reset), .wr_en(p_valid), .wr_data(p_ent),
      .full(q_full), .rd_en(q_pop), .rd_data(q_ent), .empty(q_empty)
   );

   fdc_emitter u_emitter (
      .clock(clock), .reset(reset), .q_data(q_ent), .q_empty(q_empty),
      .q_pop(q_pop), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(o_kind), .out_byte(o_byte), .out_type(o_type), .out_len(o_len),
      .out_time(o_time), .out_reason(o_rsn), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {8'd0, o_rsn, o_time, o_len, o_type, o_byte, o_kind};

   // Checks on the internal queue and result formatting.
   `ASSERT_IMPL(a_no_push_full, clock, reset, q_full, !p_valid)
   `ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   `ASSERT_IMPL(a_pay_fields, clock, reset, rsp_tvalid && o_kind == KIND_PAYLOAD, o_rsn == RSN_NONE)
   `ASSERT_NEXT(a_pop_loads, clock, reset, q_pop, rsp_tvalid)

endmodule
`default_nettype wire

// ----- rtl/fdc_parser.sv -----
// ----------------------------------------------------------------------------
// fdc_parser
// Front part: accepts bytes, tracks the frame layout, updates the CRC and
// produces one queue entry for each byte that causes results.
// ----------------------------------------------------------------------------
`default_nettype none
module fdc_parser
   import fdc_pkg::*;
#(
   parameter int RESERVED_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_take,
   input  wire logic [7:0]  in_byte,
   input  wire logic        in_first,
   input  wire logic        in_last,
   input  wire logic [15:0] header_magic,
   input  wire logic [15:0] tail_magic,
   input  wire logic [3:0]  type_shift,
   output entry_type        ent,
   output logic             ent_valid
);

   localparam int HDRBAD_END = 22 + RESERVED_BYTES;

   phase_type   phase_ff, phase_in;
   logic [6:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [63:0] shift_ff, shift_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] left_ff, left_in;
   logic [63:0] stamp_ff, stamp_in;
   logic [15:0] route_ff, route_in;
   logic        mism_ff, mism_in;

   phase_type   ph;
   logic [63:0] sh;
   logic [6:0]  cnt;
   logic [6:0]  cnt1;
   logic [63:0] sh1;
   logic [15:0] crc_cur;
   logic [15:0] crc_new;
   logic [15:0] rt_shifted;
   logic        status;

   assign crc_cur = in_first ? CRC_INIT : crc_ff;
   assign crc_new = crc_byte(crc_cur, in_byte);
   assign rt_shifted = route_ff >> type_shift;

   // Next-state and result logic for one accepted byte.
   always_comb begin
      ph       = in_first ? PH_HEADER : phase_ff;
      sh       = in_first ? 64'd0 : shift_ff;
      cnt      = in_first ? 7'd0 : count_ff;
      cnt1     = cnt + 7'd1;
      sh1      = {sh[55:0], in_byte};
      phase_in = phase_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      crc_in   = in_first ? CRC_INIT : crc_ff;
      len_in   = in_first ? 64'd0 : len_ff;
      left_in  = in_first ? 64'd0 : left_ff;
      stamp_in = in_first ? 64'd0 : stamp_ff;
      route_in = in_first ? 16'd0 : route_ff;
      mism_in  = in_first ? 1'b0 : mism_ff;
      ent      = '0;
      status   = 1'b0;
      phase_in = ph;
      count_in = cnt;
      shift_in = sh;
      case (ph)
         PH_HEADER: begin
            shift_in = sh1;
            count_in = cnt1;
            if (cnt1 >= 7'd2) begin
               phase_in = (sh1[15:0] == header_magic) ? PH_ROUTE : PH_HDRBAD;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_HDRBAD: begin
            count_in = cnt1;
            if (cnt1 >= 7'(HDRBAD_END)) begin
               ent.stat_valid  = 1'b1;
               ent.stat_kind   = KIND_REJECT;
               ent.stat_reason = RSN_HEADER;
               status   = 1'b1;
               phase_in = PH_DONE;
               count_in = '0;
            end
         end
         PH_ROUTE, PH_LENGTH, PH_STAMP: begin
            crc_in   = crc_new;
            shift_in = sh1;
            count_in = cnt1;
            if (ph == PH_ROUTE && cnt1 >= 7'd2) begin
               route_in = sh1[15:0];
               phase_in = PH_LENGTH;
               count_in = '0;
               shift_in = '0;
            end else if (ph == PH_LENGTH && cnt1 >= 7'd8) begin
               len_in   = sh1;
               left_in  = sh1;
               phase_in = PH_STAMP;
               count_in = '0;
               shift_in = '0;
            end else if (ph == PH_STAMP && cnt1 >= 7'd8) begin
               stamp_in = sh1;
               count_in = '0;
               shift_in = '0;
               if (RESERVED_BYTES > 0) phase_in = PH_RESV;
               else phase_in = (len_ff != 64'd0) ? PH_PAYLOAD : PH_CRC;
            end
         end
         PH_RESV: begin
            crc_in   = crc_new;
            count_in = cnt1;
            if (cnt1 >= 7'(RESERVED_BYTES)) begin
               phase_in = (len_ff != 64'd0) ? PH_PAYLOAD : PH_CRC;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_PAYLOAD: begin
            crc_in        = crc_new;
            ent.pay_valid = 1'b1;
            ent.pay_byte  = in_byte;
            left_in       = left_ff - 64'd1;
            if (left_ff == 64'd1) begin
               phase_in = PH_CRC;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_CRC: begin
            shift_in = sh1;
            count_in = cnt1;
            if (cnt1 >= 7'd2) begin
               mism_in  = (sh1[15:0] != crc_ff);
               phase_in = PH_TAIL;
               count_in = '0;
               shift_in = '0;
            end
         end
         PH_TAIL: begin
            shift_in = sh1;
            count_in = cnt1;
            if (cnt1 >= 7'd2) begin
               ent.stat_valid = 1'b1;
               if (sh1[15:0] != tail_magic) begin
                  ent.stat_kind   = KIND_REJECT;
                  ent.stat_reason = RSN_TAIL;
               end else if (mism_ff) begin
                  ent.stat_kind   = KIND_REJECT;
                  ent.stat_reason = RSN_CRC;
               end else begin
                  ent.stat_kind = KIND_ACCEPT;
                  ent.stat_type = rt_shifted[2:0];
                  ent.stat_len  = len_ff;
                  ent.stat_time = stamp_ff;
               end
               status   = 1'b1;
               phase_in = PH_DONE;
               count_in = '0;
               shift_in = '0;
            end
         end
         default: begin
            phase_in = ph;
         end
      endcase
      // A buffer that ends before its status is complete.
      if (in_last && !status && ph != PH_IDLE && ph != PH_DONE) begin
         ent.stat_valid  = 1'b1;
         ent.stat_kind   = KIND_REJECT;
         ent.stat_reason = RSN_EARLY;
         phase_in = PH_DONE;
         count_in = '0;
         shift_in = '0;
      end
   end

   assign ent_valid = in_take && (ent.pay_valid || ent.stat_valid);

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
         shift_ff <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
         stamp_ff <= '0;
         route_ff <= '0;
         mism_ff  <= 1'b0;
      end else if (in_take) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         shift_ff <= shift_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         stamp_ff <= stamp_in;
         route_ff <= route_in;
         mism_ff  <= mism_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/fdc_queue.sv -----
// ----------------------------------------------------------------------------
// fdc_queue
// Two-entry queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module fdc_queue
   import fdc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire entry_type wr_data,
   output logic           full,
   input  wire logic      rd_en,
   output entry_type      rd_data,
   output logic           empty
);

   entry_type   mem_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  cnt_ff;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_data = mem_ff[rptr_ff];

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wptr_ff] <= wr_data;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (wr_en) wptr_ff <= ~wptr_ff;
         if (rd_en) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + 2'(wr_en) - 2'(rd_en);
      end
   end

endmodule
`default_nettype wire

// ----- rtl/fdc_emitter.sv -----
// ----------------------------------------------------------------------------
// fdc_emitter
// Back part: splits a queue entry into one or two results on the output
// register and handles back-pressure from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module fdc_emitter
   import fdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire entry_type   q_data,
   input  wire logic        q_empty,
   output logic             q_pop,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [1:0]       out_kind,
   output logic [7:0]       out_byte,
   output logic [2:0]       out_type,
   output logic [63:0]      out_len,
   output logic [63:0]      out_time,
   output logic [2:0]       out_reason,
   output logic             out_last
);

   logic        valid_ff, valid_in;
   logic        half_ff, half_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  type_ff, type_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] time_ff, time_in;
   logic [2:0]  rsn_ff, rsn_in;
   logic        last_ff, last_in;
   logic        load;
   logic        two;

   // Register is free when empty or being taken this cycle.
   assign load = !valid_ff || out_ready;
   assign two  = q_data.pay_valid && q_data.stat_valid;

   // Pop when the status half (or the only result) of an entry loads.
   always_comb begin
      q_pop    = load && !q_empty && (!two || half_ff);
      half_in  = half_ff;
      valid_in = valid_ff && !out_ready;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      time_in  = time_ff;
      rsn_in   = rsn_ff;
      last_in  = last_ff;
      if (load && !q_empty) begin
         valid_in = 1'b1;
         if (q_data.pay_valid && !half_ff) begin
            kind_in = KIND_PAYLOAD;
            byte_in = q_data.pay_byte;
            type_in = '0;
            len_in  = '0;
            time_in = '0;
            rsn_in  = RSN_NONE;
            last_in = !two;
            half_in = two;
         end else begin
            kind_in = q_data.stat_kind;
            byte_in = '0;
            type_in = q_data.stat_type;
            len_in  = q_data.stat_len;
            time_in = q_data.stat_time;
            rsn_in  = q_data.stat_reason;
            last_in = 1'b1;
            half_in = 1'b0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      type_ff <= type_in;
      len_ff  <= len_in;
      time_ff <= time_in;
      rsn_ff  <= rsn_in;
      last_ff <= last_in;
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_byte   = byte_ff;
   assign out_type   = type_ff;
   assign out_len    = len_ff;
   assign out_time   = time_ff;
   assign out_reason = rsn_ff;
   assign out_last   = last_ff;

endmodule
`default_nettype wire

// ----- bench/frame_deframer_crc16_check_test.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check_test
// Self-checking bench for the frame deframer with CRC-16 check. Frames are
// built with random content and random flaws. A behavioral parser beside the
// block predicts every payload byte and status transaction, and the monitor
// compares each result field by field. Both sides idle at random, and the
// receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module frame_deframer_crc16_check_test;
   import fdc_pkg::*;

   localparam int RESV = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pay;
      logic [2:0]  ftype;
      logic [63:0] flen;
      logic [63:0] ftime;
      logic [2:0]  reason;
      logic        run_last;
   } status_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   frame_deframer_crc16_check #(.RESERVED_BYTES(RESV)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Pending stimulus, expected results and bench state.
   byte_item_type   pending_bytes[$];
   status_item_type expected_results[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned results_seen = 0;
   int unsigned accepts_seen = 0;
   int unsigned rejects_seen = 0;
   bit idle_enable = 1'b1;
   bit hold_request = 1'b0;
   bit offer_taken = 1'b0;
   int hold_left = 0;
   int send_gap = 0;
   int recv_gap = 0;

   // Shadow of the configuration and the parser state.
   logic [15:0] cfg_header, cfg_tail;
   logic [3:0]  cfg_shift;
   phase_type   phase;
   int          count;
   logic [15:0] crc_acc;
   logic [63:0] shifter, len_val, pay_left, stamp_val;
   logic [15:0] route;
   bit          crc_bad;

   function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
      return r;
   endfunction

   function automatic status_item_type make_status(kind_type k, logic [2:0] rsn);
      status_item_type s;
      s = '0;
      s.kind = k;
      s.reason = rsn;
      return s;
   endfunction

   task automatic enter_phase(phase_type p);
      phase = p;
      count = 0;
      shifter = '0;
   endtask

   // Advance the shadow parser by one accepted byte and queue its results.
   task automatic predict_byte(byte_item_type it);
      status_item_type outs[$];
      status_item_type s;
      bit done;
      done = 1'b0;
      if (it.first) begin
         crc_acc = 16'hFFFF; len_val = '0; pay_left = '0; stamp_val = '0;
         route = '0; crc_bad = 1'b0;
         enter_phase(PH_HEADER);
      end
      case (phase)
         PH_HEADER: begin
            shifter = (shifter << 8) | it.data; count++;
            if (count >= 2) enter_phase(shifter[15:0] == cfg_header ? PH_ROUTE : PH_HDRBAD);
         end
         PH_HDRBAD: begin
            count++;
            if (count >= 22 + RESV) begin
               outs.push_back(make_status(KIND_REJECT, RSN_HEADER));
               done = 1'b1;
               enter_phase(PH_DONE);
            end
         end
         PH_ROUTE, PH_LENGTH, PH_STAMP: begin
            crc_acc = crc16_update(crc_acc, it.data);
            shifter = (shifter << 8) | it.data; count++;
            if (phase == PH_ROUTE && count >= 2) begin
               route = shifter[15:0]; enter_phase(PH_LENGTH);
            end else if (phase == PH_LENGTH && count >= 8) begin
               len_val = shifter; pay_left = shifter; enter_phase(PH_STAMP);
            end else if (phase == PH_STAMP && count >= 8) begin
               stamp_val = shifter;
               if (RESV > 0) enter_phase(PH_RESV);
               else enter_phase(len_val != 0 ? PH_PAYLOAD : PH_CRC);
            end
         end
         PH_RESV: begin
            crc_acc = crc16_update(crc_acc, it.data); count++;
            if (count >= RESV) enter_phase(len_val != 0 ? PH_PAYLOAD : PH_CRC);
         end
         PH_PAYLOAD: begin
            crc_acc = crc16_update(crc_acc, it.data);
            s = make_status(KIND_PAYLOAD, RSN_NONE);
            s.pay = it.data;
            outs.push_back(s);
            pay_left--;
            if (pay_left == 0) enter_phase(PH_CRC);
         end
         PH_CRC: begin
            shifter = (shifter << 8) | it.data; count++;
            if (count >= 2) begin
               crc_bad = shifter[15:0] != crc_acc; enter_phase(PH_TAIL);
            end
         end
         PH_TAIL: begin
            shifter = (shifter << 8) | it.data; count++;
            if (count >= 2) begin
               if (shifter[15:0] != cfg_tail) s = make_status(KIND_REJECT, RSN_TAIL);
               else if (crc_bad) s = make_status(KIND_REJECT, RSN_CRC);
               else begin
                  s = make_status(KIND_ACCEPT, RSN_NONE);
                  s.ftype = 3'((route >> cfg_shift) & 16'h7);
                  s.flen = len_val;
                  s.ftime = stamp_val;
               end
               outs.push_back(s);
               done = 1'b1;
               enter_phase(PH_DONE);
            end
         end
         default: return;
      endcase
      if (it.last && !done) begin
         outs.push_back(make_status(KIND_REJECT, RSN_EARLY));
         enter_phase(PH_DONE);
      end
      if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
      foreach (outs[i]) expected_results.push_back(outs[i]);
   endtask

   // Build a frame; flaw 0 none, 1 header, 2 tail, 3 crc, 4 crc and tail,
   // 5 cut short, 6 restart in the middle, 7 trailing junk.
   task automatic add_frame(int plen, int flaw, logic [63:0] lenf, logic [63:0] stamp);
      logic [7:0] buf_q[$];
      logic [15:0] crc, route_w, hm, tm;
      int cut;
      route_w = 16'($urandom);
      hm = (flaw == 1) ? cfg_header ^ 16'(1 << $urandom_range(0, 15)) : cfg_header;
      tm = (flaw == 2 || flaw == 4) ? ~cfg_tail : cfg_tail;
      buf_q = {hm[15:8], hm[7:0], route_w[15:8], route_w[7:0]};
      for (int i = 7; i >= 0; i--) buf_q.push_back(lenf[8*i +: 8]);
      for (int i = 7; i >= 0; i--) buf_q.push_back(stamp[8*i +: 8]);
      for (int i = 0; i < RESV + plen; i++) buf_q.push_back(8'($urandom));
      crc = 16'hFFFF;
      for (int i = 2; i < buf_q.size(); i++) crc = crc16_update(crc, buf_q[i]);
      if (flaw == 3 || flaw == 4) crc = crc ^ 16'(1 << $urandom_range(0, 15));
      buf_q.push_back(crc[15:8]); buf_q.push_back(crc[7:0]);
      buf_q.push_back(tm[15:8]); buf_q.push_back(tm[7:0]);
      if (flaw == 5 || flaw == 6) begin
         cut = $urandom_range(1, buf_q.size() - 1);
         while (buf_q.size() > cut) void'(buf_q.pop_back());
      end
      if (flaw == 7) repeat ($urandom_range(1, 4)) buf_q.push_back(8'($urandom));
      foreach (buf_q[i]) begin
         byte_item_type it;
         it.data = buf_q[i];
         it.first = (i == 0);
         it.last = (i == buf_q.size() - 1) && flaw != 6 && flaw != 7;
         if (flaw == 7 && i == buf_q.size() - 1) it.last = 1'b1;
         pending_bytes.push_back(it);
      end
   endtask

   task automatic add_good(int plen, int flaw);
      add_frame(plen, flaw, 64'(plen), {$urandom, $urandom});
   endtask

   // Accepted transactions are taken from the queue at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_byte(pending_bytes.pop_front());
         bytes_sent++;
         offer_taken = 1'b1;
      end
   end

   // Driver: offers queued bytes at the falling edge with random gaps. An
   // offer stays unchanged until it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || offer_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_bytes[0].data;
            req_tuser <= pending_bytes[0].first;
            req_tlast <= pending_bytes[0].last;
            if (idle_enable && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      offer_taken = 1'b0;
   end

   // Receiver readiness, including the long hold-off.
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = 300;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_enable && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 6);
      end
   end

   // Monitor: compares each result with the oldest expectation.
   always @(posedge clock) begin
      status_item_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = kind_type'(rsp_tdata[1:0]);
         got.pay = rsp_tdata[9:2];
         got.ftype = rsp_tdata[12:10];
         got.flen = rsp_tdata[76:13];
         got.ftime = rsp_tdata[140:77];
         got.reason = rsp_tdata[143:141];
         got.run_last = rsp_tlast;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want || rsp_tdata[151:144] !== 8'h00) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
            if (want.kind == KIND_ACCEPT) accepts_seen++;
            if (want.kind == KIND_REJECT) rejects_seen++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 4'(idx) << 2; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_HEADER: cfg_header = value[15:0];
         REG_TAIL:   cfg_tail = value[15:0];
         default:    cfg_shift = value[3:0];
      endcase
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] h, logic [15:0] t, logic [3:0] s);
      write_reg(REG_HEADER, 32'(h));
      write_reg(REG_TAIL, 32'(t));
      write_reg(REG_SHIFT, 32'(s));
   endtask

   task automatic random_frames(int n_bytes);
      int flaw, r;
      int start;
      start = bytes_sent + pending_bytes.size();
      while (bytes_sent + pending_bytes.size() - start < n_bytes) begin
         r = $urandom_range(0, 19);
         flaw = r < 10 ? 0 : r - 10;
         if (flaw > 7) flaw = 0;
         if (r == 19) begin
            // Loose bytes outside any buffer.
            byte_item_type it;
            it.data = 8'($urandom); it.first = 1'b0; it.last = 1'($urandom);
            pending_bytes.push_back(it);
         end else begin
            add_good($urandom_range(0, 12), flaw);
         end
      end
   endtask

   initial begin
      cfg_header = '0; cfg_tail = '0; cfg_shift = '0;
      crc_acc = 16'hFFFF; len_val = '0; pay_left = '0; stamp_val = '0;
      route = '0; crc_bad = 1'b0;
      enter_phase(PH_IDLE);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset defaults, then every flaw and field extreme.
      add_good(0, 0);
      drain();
      configure(16'hA55A, 16'h5AA5, 4'd13);
      add_frame(3, 0, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF);
      add_frame(1, 0, 64'd1, 64'd0);
      for (int f = 1; f <= 7; f++) add_good(2, f);
      add_frame(0, 5, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      drain();
      configure(16'hFFFF, 16'hFFFF, 4'd15);
      add_good(4, 0); add_good(1, 5); add_good(0, 0);
      drain();
      configure(16'h0000, 16'h0000, 4'd14);
      add_good(2, 0);
      drain();

      // Random phases under several settings, long receiver stall in one.
      for (int ph = 0; ph < 4; ph++) begin
         configure(16'($urandom), 16'($urandom), 4'($urandom_range(0, 15)));
         if (ph == 1) hold_request = 1'b1;
         if (ph == 3) idle_enable = 1'b0;
         random_frames(250);
         drain();
      end

      $display("covered %0d bytes, %0d results: %0d accepted, %0d rejected frames",
               bytes_sent, results_seen, accepts_seen, rejects_seen);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fdc_pkg.sv
rtl/fdc_parser.sv
rtl/fdc_queue.sv
rtl/fdc_emitter.sv
rtl/frame_deframer_crc16_check.sv
bench/frame_deframer_crc16_check_test.sv
